>>> hdl/pld_pkg.sv
// Shared constants and types for the polyline point decimator.
// Depends on nothing; files but pld_in_if and pld_checker use it by scoped names.
package pld_pkg;

    // Configuration register widths.
    localparam int JUMP_LIMIT_W   = 20;
    localparam int MIN_MOVE_W     = 8;
    localparam int STROKE_WIDTH_W = 16;
    localparam int STROKE_COLOR_W = 32;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_INDEX_W    = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_JUMP_LIMIT   = 2'd0,
        REG_MIN_MOVE     = 2'd1,
        REG_STROKE_WIDTH = 2'd2,
        REG_STROKE_COLOR = 2'd3
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [JUMP_LIMIT_W-1:0]   JUMP_LIMIT_RST   = 20'd25920;
    localparam logic [MIN_MOVE_W-1:0]     MIN_MOVE_RST     = 8'd19;
    localparam logic [STROKE_WIDTH_W-1:0] STROKE_WIDTH_RST = 16'd16;
    localparam logic [STROKE_COLOR_W-1:0] STROKE_COLOR_RST = 32'hFFFF_FFFF;

    // Vertex queue between the classifier and the output stage.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int PUSH_W  = 2;

endpackage

>>> hdl/pld_in_if.sv
// Sample channel of the polyline point decimator: valid/ready plus one curve sample.
// Depends on nothing.
interface pld_in_if #(
    parameter int COORD_BITS = 20
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_pos;
    logic signed [COORD_BITS-1:0] y_pos;
    logic                         sample_ok;
    logic                         last_sample;

    modport source (output valid, output x_pos, output y_pos, output sample_ok,
                    output last_sample, input ready);
    modport sink   (input valid, input x_pos, input y_pos, input sample_ok,
                    input last_sample, output ready);
endinterface

>>> hdl/pld_out_if.sv
// Vertex channel of the polyline point decimator: valid/ready plus one polyline vertex.
// Uses pld_pkg for the stroke field widths.
interface pld_out_if #(
    parameter int COORD_BITS = 20
);
    logic                                      valid;
    logic                                      ready;
    logic signed [COORD_BITS-1:0]              out_x;
    logic signed [COORD_BITS-1:0]              out_y;
    logic                                      run_first;
    logic                                      run_last;
    logic [pld_pkg::STROKE_WIDTH_W-1:0]        run_width;
    logic [pld_pkg::STROKE_COLOR_W-1:0]        run_color;

    modport source (output valid, output out_x, output out_y, output run_first,
                    output run_last, output run_width, output run_color, input ready);
    modport sink   (input valid, input out_x, input out_y, input run_first,
                    input run_last, input run_width, input run_color, output ready);
endinterface

>>> hdl/polyline_point_decimator.sv
// Polyline point decimator: groups screen-space curve samples into polyline runs.
// Channels: in_ch carries samples (x_pos, y_pos in 1/16 px, sample_ok, last_sample),
// out_ch carries vertices with run_first/run_last flags and the stroke settings.
// Both use valid/ready; a transaction happens on a clock edge with both high.
// The cfg_we/cfg_index/cfg_data port writes jump_limit, min_move, stroke_width and
// stroke_color; write it only while the block is idle.
// A sample is classified in the cycle it is accepted, and its zero, one or two
// vertices enter a four-entry queue at that edge. The first of them reaches out_ch
// through the queue and then the output register.
// Throughput: one sample per cycle while the queue has room; the output stage
// delivers one vertex per cycle while out_ch.ready is high, so two-vertex samples
// fill the queue. in_ch.ready is high while the queue has two free entries.
// When the receiver stalls, the held vertex stays stable and the queue fills, which
// then drops in_ch.ready. Reset clears the run state and the queue, and returns the
// configuration registers to their defaults.
// Depends on pld_pkg, pld_in_if, pld_out_if, pld_front, pld_queue and pld_back.
module polyline_point_decimator #(
    parameter int COORD_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pld_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pld_pkg::CFG_DATA_W-1:0]      cfg_data,
    pld_in_if.sink                              in_ch,
    pld_out_if.source                           out_ch
);
    logic [pld_pkg::JUMP_LIMIT_W-1:0]    jump_limit_reg;
    logic [pld_pkg::MIN_MOVE_W-1:0]      min_move_reg;
    logic [pld_pkg::STROKE_WIDTH_W-1:0]  stroke_width_reg;
    logic [pld_pkg::STROKE_COLOR_W-1:0]  stroke_color_reg;

    logic                         accept;
    logic                         room;
    logic [pld_pkg::PUSH_W-1:0]   push_cnt;
    logic [2*COORD_BITS+1:0]      push_e0;
    logic [2*COORD_BITS+1:0]      push_e1;
    logic                         pop;
    logic                         head_valid;
    logic [2*COORD_BITS+1:0]      head;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_limit_reg   <= pld_pkg::JUMP_LIMIT_RST;
            min_move_reg     <= pld_pkg::MIN_MOVE_RST;
            stroke_width_reg <= pld_pkg::STROKE_WIDTH_RST;
            stroke_color_reg <= pld_pkg::STROKE_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (pld_pkg::cfg_reg_t'(cfg_index))
                pld_pkg::REG_JUMP_LIMIT:
                    jump_limit_reg <= cfg_data[pld_pkg::JUMP_LIMIT_W-1:0];
                pld_pkg::REG_MIN_MOVE:
                    min_move_reg <= cfg_data[pld_pkg::MIN_MOVE_W-1:0];
                pld_pkg::REG_STROKE_WIDTH:
                    stroke_width_reg <= cfg_data[pld_pkg::STROKE_WIDTH_W-1:0];
                pld_pkg::REG_STROKE_COLOR:
                    stroke_color_reg <= cfg_data[pld_pkg::STROKE_COLOR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    pld_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .x_pos       (in_ch.x_pos),
        .y_pos       (in_ch.y_pos),
        .sample_ok   (in_ch.sample_ok),
        .last_sample (in_ch.last_sample),
        .jump_limit  (jump_limit_reg),
        .min_move    (min_move_reg),
        .push_cnt    (push_cnt),
        .push_e0     (push_e0),
        .push_e1     (push_e1)
    );

    pld_queue #(.COORD_BITS(COORD_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_e0    (push_e0),
        .push_e1    (push_e1),
        .pop        (pop),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    pld_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .stroke_width (stroke_width_reg),
        .stroke_color (stroke_color_reg),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_x        (out_ch.out_x),
        .out_y        (out_ch.out_y),
        .run_first    (out_ch.run_first),
        .run_last     (out_ch.run_last),
        .run_width    (out_ch.run_width),
        .run_color    (out_ch.run_color)
    );

endmodule

>>> hdl/pld_front.sv
// Classifier: keeps the run state and turns each sample into zero, one or two vertices.
// Uses pld_pkg for register widths and the push count width.
module pld_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic signed [COORD_BITS-1:0]         x_pos,
    input  logic signed [COORD_BITS-1:0]         y_pos,
    input  logic                                 sample_ok,
    input  logic                                 last_sample,
    input  logic [pld_pkg::JUMP_LIMIT_W-1:0]     jump_limit,
    input  logic [pld_pkg::MIN_MOVE_W-1:0]       min_move,
    output logic [pld_pkg::PUSH_W-1:0]           push_cnt,
    output logic [2*COORD_BITS+1:0]              push_e0,
    output logic [2*COORD_BITS+1:0]              push_e1
);
    localparam int AW = COORD_BITS + 1;
    localparam int DW = (AW > pld_pkg::JUMP_LIMIT_W) ? AW : pld_pkg::JUMP_LIMIT_W;
    localparam int EW = 2 * COORD_BITS + 2;

    typedef struct packed {
        logic                         hp;
        logic signed [COORD_BITS-1:0] prev_y;
        logic signed [COORD_BITS-1:0] kx;
        logic signed [COORD_BITS-1:0] ky;
        logic                         ku;
        logic                         ro;
        logic                         df;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
    } run_state_t;

    typedef struct packed {
        run_state_t                 s;
        logic [pld_pkg::PUSH_W-1:0] cnt;
        logic [EW-1:0]              e0;
        logic [EW-1:0]              e1;
    } work_t;

    run_state_t st_reg;
    run_state_t st_next;
    work_t      w;
    logic       jump;
    logic       near;

    function automatic logic [AW-1:0] absd(input logic signed [COORD_BITS-1:0] a,
                                           input logic signed [COORD_BITS-1:0] b);
        logic signed [AW-1:0] d;
        d = AW'(a) - AW'(b);
        return d[AW-1] ? AW'(-d) : AW'(d);
    endfunction

    function automatic work_t emit_v(input work_t wi,
                                     input logic signed [COORD_BITS-1:0] x,
                                     input logic signed [COORD_BITS-1:0] y,
                                     input logic first, input logic last);
        work_t r;
        r = wi;
        if (wi.cnt == '0)
            r.e0 = {x, y, first, last};
        else
            r.e1 = {x, y, first, last};
        r.cnt = wi.cnt + pld_pkg::PUSH_W'(1);
        return r;
    endfunction

    function automatic work_t push_v(input work_t wi,
                                     input logic signed [COORD_BITS-1:0] x,
                                     input logic signed [COORD_BITS-1:0] y);
        work_t r;
        r = wi;
        if (r.s.ku)
        begin
            r = emit_v(r, r.s.kx, r.s.ky, !r.s.ro, 1'b0);
            r.s.ro = 1'b1;
        end
        r.s.kx = x;
        r.s.ky = y;
        r.s.ku = 1'b1;
        r.s.df = 1'b0;
        return r;
    endfunction

    function automatic work_t close_v(input work_t wi);
        work_t r;
        r = wi;
        if (r.s.df)
            r = push_v(r, r.s.dx, r.s.dy);
        if (r.s.ku && r.s.ro)
            r = emit_v(r, r.s.kx, r.s.ky, 1'b0, 1'b1);
        r.s.ku = 1'b0;
        r.s.ro = 1'b0;
        r.s.df = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        jump = DW'(absd(y_pos, st_reg.prev_y)) > DW'(jump_limit);
        near = (absd(x_pos, st_reg.kx) < AW'(min_move)) &&
               (absd(y_pos, st_reg.ky) < AW'(min_move));

        w.s   = st_reg;
        w.cnt = '0;
        w.e0  = '0;
        w.e1  = '0;

        if (!sample_ok)
        begin
            w      = close_v(w);
            w.s.hp = 1'b0;
        end
        else
        begin
            if (w.s.hp && jump)
            begin
                w      = close_v(w);
                w.s.hp = 1'b0;
            end
            w.s.prev_y = y_pos;
            // The kept vertex is unchanged whenever hp survived, so near still applies.
            if (w.s.hp && near)
            begin
                w.s.df = 1'b1;
                w.s.dx = x_pos;
                w.s.dy = y_pos;
            end
            else
            begin
                w      = push_v(w, x_pos, y_pos);
                w.s.hp = 1'b1;
            end
        end

        if (last_sample)
        begin
            w      = close_v(w);
            w.s.hp = 1'b0;
        end

        st_next  = accept ? w.s : st_reg;
        push_cnt = accept ? w.cnt : '0;
        push_e0  = w.e0;
        push_e1  = w.e1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

>>> hdl/pld_queue.sv
// Short vertex queue: takes up to two vertices per cycle, hands out one per cycle.
// Uses pld_pkg for its depth and pointer widths.
module pld_queue #(
    parameter int COORD_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pld_pkg::PUSH_W-1:0]  push_cnt,
    input  logic [2*COORD_BITS+1:0]     push_e0,
    input  logic [2*COORD_BITS+1:0]     push_e1,
    input  logic                        pop,
    output logic                        room,
    output logic                        head_valid,
    output logic [2*COORD_BITS+1:0]     head
);
    localparam int EW = 2 * COORD_BITS + 2;

    logic [EW-1:0]                  mem [pld_pkg::QDEPTH];
    logic [pld_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pld_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [pld_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pld_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [pld_pkg::QCNT_W-1:0]     cnt_reg;
    logic [pld_pkg::QCNT_W-1:0]     cnt_next;

    // Room means two free entries, the most one sample can produce.
    assign room       = cnt_reg <= pld_pkg::QCNT_W'(pld_pkg::QDEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pld_pkg::QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + pld_pkg::QPTR_W'(pop);
        cnt_next    = cnt_reg + pld_pkg::QCNT_W'(push_cnt) - pld_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
            mem[wr_ptr_reg] <= push_e0;
        if (push_cnt == pld_pkg::PUSH_W'(2))
            mem[wr_ptr_reg + pld_pkg::QPTR_W'(1)] <= push_e1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hdl/pld_back.sv
// Output stage: registers the queue head with the current stroke settings and
// holds it until the receiver takes it. Uses pld_pkg for the stroke field widths.
module pld_back #(
    parameter int COORD_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_valid,
    input  logic [2*COORD_BITS+1:0]              head,
    output logic                                 pop,
    input  logic [pld_pkg::STROKE_WIDTH_W-1:0]   stroke_width,
    input  logic [pld_pkg::STROKE_COLOR_W-1:0]   stroke_color,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [COORD_BITS-1:0]         out_x,
    output logic signed [COORD_BITS-1:0]         out_y,
    output logic                                 run_first,
    output logic                                 run_last,
    output logic [pld_pkg::STROKE_WIDTH_W-1:0]   run_width,
    output logic [pld_pkg::STROKE_COLOR_W-1:0]   run_color
);
    logic                                valid_reg;
    logic                                valid_next;
    logic [2*COORD_BITS+1:0]             vtx_reg;
    logic [pld_pkg::STROKE_WIDTH_W-1:0]  width_reg;
    logic [pld_pkg::STROKE_COLOR_W-1:0]  color_reg;

    assign pop        = head_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    assign out_valid = valid_reg;
    assign out_x     = vtx_reg[2*COORD_BITS+1:COORD_BITS+2];
    assign out_y     = vtx_reg[COORD_BITS+1:2];
    assign run_first = vtx_reg[1];
    assign run_last  = vtx_reg[0];
    assign run_width = width_reg;
    assign run_color = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            vtx_reg   <= head;
            width_reg <= stroke_width;
            color_reg <= stroke_color;
        end
    end

endmodule

>>> hdl/pld_checker.sv
// Port-level checks of the polyline point decimator's vertex stream, bound to the top.
// Depends on polyline_point_decimator and its out_ch interface.
module pld_checker #(
    parameter int COORD_BITS = 20
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_BITS-1:0] out_x,
    input logic signed [COORD_BITS-1:0] out_y,
    input logic                         run_first,
    input logic                         run_last
);
    // Tracks whether a run has started on the output and not yet ended.
    logic in_run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_run_reg <= 1'b0;
        else if (out_valid && out_ready)
            in_run_reg <= !run_last;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
                                    $stable(run_first) && $stable(run_last))
        else $error("vertex changed while stalled");

    a_two_points: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && run_first && run_last))
        else $error("run with a single vertex was emitted");

    a_first_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_first |-> !in_run_reg)
        else $error("run started before the previous run ended");

    a_inner_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_first |-> in_run_reg)
        else $error("vertex emitted outside of a run");

endmodule

bind polyline_point_decimator pld_checker #(.COORD_BITS(COORD_BITS)) u_pld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .run_first (out_ch.run_first),
    .run_last  (out_ch.run_last)
);

>>> test/tb_polyline_point_decimator.sv
// Self-checking testbench for polyline_point_decimator: directed and random curve samples,
// with a scoreboard class that predicts the vertex stream and checks it field by field.
// Depends on pld_pkg, pld_in_if, pld_out_if and the polyline_point_decimator RTL.
module tb_polyline_point_decimator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = 20;
    localparam int CLK_PERIOD    = 10;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 175;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    localparam int STALL_LIMIT   = 3000;
    localparam int PRINT_LIMIT   = 40;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
        bit     ok;
        bit     fin;
    } sample_t;

    typedef struct {
        coord_t                             x;
        coord_t                             y;
        logic                               first;
        logic                               last;
        logic [pld_pkg::STROKE_WIDTH_W-1:0] width;
        logic [pld_pkg::STROKE_COLOR_W-1:0] color;
    } vertex_t;

    // Predicts the vertex stream from accepted samples and checks the received vertices.
    class run_scoreboard;
        logic [pld_pkg::JUMP_LIMIT_W-1:0]   jump_lim;
        logic [pld_pkg::MIN_MOVE_W-1:0]     min_step;
        logic [pld_pkg::STROKE_WIDTH_W-1:0] stroke_w;
        logic [pld_pkg::STROKE_COLOR_W-1:0] stroke_c;
        bit      trace_ok;
        bit      held_pending;
        bit      run_started;
        bit      parked;
        coord_t  last_y;
        coord_t  held_x;
        coord_t  held_y;
        coord_t  parked_x;
        coord_t  parked_y;
        vertex_t expected_vertices[$];
        int      mismatches;
        int      vertices_checked;
        int      runs_checked;

        function new();
            jump_lim         = pld_pkg::JUMP_LIMIT_RST;
            min_step         = pld_pkg::MIN_MOVE_RST;
            stroke_w         = pld_pkg::STROKE_WIDTH_RST;
            stroke_c         = pld_pkg::STROKE_COLOR_RST;
            trace_ok         = 1'b0;
            held_pending     = 1'b0;
            run_started      = 1'b0;
            parked           = 1'b0;
            last_y           = '0;
            held_x           = '0;
            held_y           = '0;
            parked_x         = '0;
            parked_y         = '0;
            mismatches       = 0;
            vertices_checked = 0;
            runs_checked     = 0;
        endfunction

        function void write_register(pld_pkg::cfg_reg_t idx,
                                     logic [pld_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                pld_pkg::REG_JUMP_LIMIT:   jump_lim = val[pld_pkg::JUMP_LIMIT_W-1:0];
                pld_pkg::REG_MIN_MOVE:     min_step = val[pld_pkg::MIN_MOVE_W-1:0];
                pld_pkg::REG_STROKE_WIDTH: stroke_w = val[pld_pkg::STROKE_WIDTH_W-1:0];
                pld_pkg::REG_STROKE_COLOR: stroke_c = val[pld_pkg::STROKE_COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit idle();
            return expected_vertices.size() == 0;
        endfunction

        function int span(int a, int b);
            int d;
            d = a - b;
            return (d < 0) ? -d : d;
        endfunction

        function void add_vertex(coord_t x, coord_t y, bit first, bit last);
            vertex_t v;
            v.x     = x;
            v.y     = y;
            v.first = first;
            v.last  = last;
            v.width = stroke_w;
            v.color = stroke_c;
            expected_vertices.insert(expected_vertices.size(), v);
        endfunction

        // The held vertex goes out only once the next one is known, so its flags are exact.
        function void keep_vertex(coord_t x, coord_t y);
            if (held_pending)
            begin
                add_vertex(held_x, held_y, !run_started, 1'b0);
                run_started = 1'b1;
            end
            held_x       = x;
            held_y       = y;
            held_pending = 1'b1;
            parked       = 1'b0;
        endfunction

        function void close_run();
            if (parked)
                keep_vertex(parked_x, parked_y);
            if (held_pending && run_started)
                add_vertex(held_x, held_y, 1'b0, 1'b1);
            held_pending = 1'b0;
            run_started  = 1'b0;
            parked       = 1'b0;
        endfunction

        function void note_sample(sample_t s);
            int xi;
            int yi;
            xi = int'(s.x);
            yi = int'(s.y);
            if (!s.ok)
            begin
                close_run();
                trace_ok = 1'b0;
            end
            else
            begin
                if (trace_ok && span(yi, int'(last_y)) > int'(jump_lim))
                begin
                    close_run();
                    trace_ok = 1'b0;
                end
                last_y = s.y;
                if (trace_ok && span(xi, int'(held_x)) < int'(min_step)
                        && span(yi, int'(held_y)) < int'(min_step))
                begin
                    parked   = 1'b1;
                    parked_x = s.x;
                    parked_y = s.y;
                end
                else
                begin
                    keep_vertex(s.x, s.y);
                    trace_ok = 1'b1;
                end
            end
            if (s.fin)
            begin
                close_run();
                trace_ok = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] vertex %0d: %s", $time, vertices_checked, msg);
        endtask

        task check_vertex(vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                report_mismatch($sformatf("unexpected vertex (%0d,%0d)", got.x, got.y));
                return;
            end
            want = expected_vertices.pop_front();
            if (got.x !== want.x)
                report_mismatch($sformatf("out_x %0d, expected %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("out_y %0d, expected %0d", got.y, want.y));
            if (got.first !== want.first)
                report_mismatch($sformatf("run_first %b, expected %b", got.first, want.first));
            if (got.last !== want.last)
                report_mismatch($sformatf("run_last %b, expected %b", got.last, want.last));
            if (got.width !== want.width)
                report_mismatch($sformatf("run_width %0d, expected %0d", got.width, want.width));
            if (got.color !== want.color)
                report_mismatch($sformatf("run_color %h, expected %h", got.color, want.color));
            vertices_checked++;
            if (want.last)
                runs_checked++;
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we;
    logic [pld_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pld_pkg::CFG_DATA_W-1:0]  cfg_data;

    pld_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
    pld_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

    polyline_point_decimator #(.COORD_BITS(COORD_BITS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    run_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests = 0;
    int samples_sent = 0;
    int idle_cycles = 0;
    int cur_jump;
    int cur_move;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: random back-pressure, plus a long hold whenever the stimulus asks for one.
    initial
    begin : vertex_receiver
        int hold_left;
        int holds_seen;
        hold_left    = 0;
        holds_seen   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : vertex_monitor
        vertex_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.x     = out_ch.out_x;
            got.y     = out_ch.out_y;
            got.first = out_ch.run_first;
            got.last  = out_ch.run_last;
            got.width = out_ch.run_width;
            got.color = out_ch.run_color;
            sb.check_vertex(got);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic coord_t rand_coord();
        return coord_t'($urandom());
    endfunction

    function automatic sample_t mk_sample(int x, int y, bit ok, bit fin);
        sample_t s;
        s.x   = coord_t'(x);
        s.y   = coord_t'(y);
        s.ok  = ok;
        s.fin = fin;
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.x_pos       <= s.x;
        in_ch.y_pos       <= s.y;
        in_ch.sample_ok   <= s.ok;
        in_ch.last_sample <= s.fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        while (!sb.idle())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(pld_pkg::cfg_reg_t idx,
                                  logic [pld_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_register(idx, val);
    endtask

    task automatic apply_settings(logic [pld_pkg::CFG_DATA_W-1:0] jl,
                                  logic [pld_pkg::CFG_DATA_W-1:0] mm,
                                  logic [pld_pkg::CFG_DATA_W-1:0] sw,
                                  logic [pld_pkg::CFG_DATA_W-1:0] sc);
        write_register(pld_pkg::REG_JUMP_LIMIT, jl);
        write_register(pld_pkg::REG_MIN_MOVE, mm);
        write_register(pld_pkg::REG_STROKE_WIDTH, sw);
        write_register(pld_pkg::REG_STROKE_COLOR, sc);
        cfg_we   <= 1'b0;
        cur_jump = int'(jl[pld_pkg::JUMP_LIMIT_W-1:0]);
        cur_move = int'(mm[pld_pkg::MIN_MOVE_W-1:0]);
    endtask

    // One curve: mostly plausible steps, with deferred wiggles, jumps and pen lifts mixed in.
    task automatic send_trace(int len);
        coord_t x;
        coord_t y;
        int     dx;
        int     dy;
        int     r;
        int     step_max;
        bit     ok;
        bit     fin;
        x        = rand_coord();
        y        = rand_coord();
        step_max = cur_move * 3 + 64;
        for (int i = 0; i < len; i++)
        begin
            r  = $urandom_range(99);
            ok = 1'b1;
            dx = int'($urandom_range(2 * step_max)) - step_max;
            dy = int'($urandom_range(2 * step_max)) - step_max;
            if (r < 5)
                ok = 1'b0;
            else if (r < 11)
            begin
                // Vertical step right at the break threshold or just past it.
                dy = cur_jump + int'($urandom_range(2));
                if ($urandom_range(1))
                    dy = -dy;
            end
            else if (r < 14)
            begin
                y  = rand_coord();
                dy = 0;
            end
            else if (r < 45)
            begin
                dx = int'($urandom_range(2 * cur_move)) - cur_move;
                dy = int'($urandom_range(2 * cur_move)) - cur_move;
            end
            x   = x + dx;
            y   = y + dy;
            fin = (i == len - 1) && ($urandom_range(9) != 0);
            send_sample(mk_sample(int'(x), int'(y), ok, fin));
        end
    endtask

    initial
    begin : stimulus
        int  phase_end;
        bit  hold_done;
        in_ch.valid       = 1'b0;
        in_ch.x_pos       = '0;
        in_ch.y_pos       = '0;
        in_ch.sample_ok   = 1'b0;
        in_ch.last_sample = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = pld_pkg::REG_JUMP_LIMIT;
        cfg_data          = '0;
        send_idle_pct     = 21;
        recv_idle_pct     = 76;
        cur_jump          = int'(pld_pkg::JUMP_LIMIT_RST);
        cur_move          = int'(pld_pkg::MIN_MOVE_RST);
        hold_done         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: jump limit 25920, minimum move 19.
        // Full-scale x move, vertical step exactly at the limit, then one past it.
        send_sample(mk_sample(-524288, -524288, 1, 0));
        send_sample(mk_sample(524287, -524288, 1, 0));
        send_sample(mk_sample(524287, -498368, 1, 0));
        send_sample(mk_sample(524287, -472447, 1, 0));
        // Deferred just inside the threshold, kept exactly at it, and a deferred point
        // that becomes the final vertex when the curve ends.
        send_sample(mk_sample(524269, -472429, 1, 0));
        send_sample(mk_sample(524268, -472447, 1, 0));
        send_sample(mk_sample(524273, -472442, 1, 1));
        // A run of a single vertex is dropped.
        send_sample(mk_sample(0, 0, 1, 1));
        // Pen lift in the middle of a run.
        send_sample(mk_sample(100, 100, 1, 0));
        send_sample(mk_sample(2000, 2000, 1, 0));
        send_sample(mk_sample(-1, -1, 0, 0));
        // Pen lift that is also the last sample, with and without an open run.
        send_sample(mk_sample(5000, 5000, 1, 0));
        send_sample(mk_sample(9000, 9000, 1, 0));
        send_sample(mk_sample(0, 0, 0, 1));
        send_sample(mk_sample(-524288, 524287, 0, 1));
        // A deferred point is flushed as the last vertex when a jump breaks the run.
        send_sample(mk_sample(0, 0, 1, 0));
        send_sample(mk_sample(1000, 0, 1, 0));
        send_sample(mk_sample(1005, 3, 1, 0));
        send_sample(mk_sample(1005, 30000, 1, 0));
        send_sample(mk_sample(2000, 30000, 1, 1));
        // Full-scale vertical jumps leave only single-vertex runs.
        send_sample(mk_sample(-524288, 524287, 1, 0));
        send_sample(mk_sample(524287, -524288, 1, 0));
        send_sample(mk_sample(-1, 0, 1, 1));
        wait_until_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
            else if (p == 1)
                apply_settings(32'h000F_FFFF, 32'h0000_00FF, 32'h0000_FFFF, 32'hFFFF_FFFF);
            else
                apply_settings({12'($urandom()), 20'($urandom_range(40000))},
                               {24'($urandom()), 8'($urandom_range(1, 60))},
                               $urandom(), $urandom());
            if (p < 2)
            begin
                send_idle_pct = 21;
                recv_idle_pct <= 76;
            end
            else if (p < 4)
            begin
                send_idle_pct = 76;
                recv_idle_pct <= 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            phase_end = samples_sent + PHASE_ITEMS;
            while (samples_sent < phase_end)
            begin
                // With neither side idling, one long output hold backs up the input.
                if (p == PHASE_COUNT - 2 && !hold_done && samples_sent + 140 < phase_end)
                begin
                    hold_requests <= hold_requests + 1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(99) < 85)
                    send_trace($urandom_range(1, 14));
                else
                    send_sample(mk_sample(int'(rand_coord()), int'(rand_coord()),
                                          1'($urandom_range(1)), 1'($urandom_range(1))));
            end
            wait_until_drained();
        end

        $display("Ran %0d samples over %0d register settings; %0d vertices in %0d runs checked.",
                 samples_sent, PHASE_COUNT + 1, sb.vertices_checked, sb.runs_checked);
        $display("Both channels stalled at random, and one long output hold filled the block.");
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
